[hdl/column_l2_normalizer_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the column l2 normalizer checker.
// ----------------------------------------------------------------------------
`ifndef COLUMN_L2_NORMALIZER_CORE_MACROS_SVH
`define COLUMN_L2_NORMALIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define CLN_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define CLN_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cln_pkg.sv]
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types and constants of the column l2 normalizer.
// ----------------------------------------------------------------------------
package cln_pkg;

	localparam int COL_W   = 6;
	localparam int VALUE_W = 32;
	localparam int SUM_W   = 64;
	localparam int NORM_W  = 32;
	localparam int CFG_W   = 7;
	localparam int FRAC_SHIFT = 30;

	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_NORM  = 1'b1;
	localparam logic KIND_NORM = 1'b0;
	localparam logic KIND_ELEM = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_ACC_MUL  = 10'b0000000010,
		S_ACC_WR   = 10'b0000000100,
		S_SW_RD    = 10'b0000001000,
		S_SW_START = 10'b0000010000,
		S_SW_WAIT  = 10'b0000100000,
		S_SW_OUT   = 10'b0001000000,
		S_DV_CHK   = 10'b0010000000,
		S_DV_WAIT  = 10'b0100000000,
		S_DV_OUT   = 10'b1000000000
	} cln_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cln_unit_stat_t;

endpackage

[hdl/column_l2_normalizer_core.sv]
// ----------------------------------------------------------------------------
// column_l2_normalizer_core
// Accumulate item: read, square, saturating write back.
// Last accumulate item: plus a pass over all columns with the bit-serial square root.
// Normalize item: quotient from the radix-4 divider, or zero or a saturated value without it.
// Reset: square sums read as zero through per-column valid bits; no clear pass.
// ----------------------------------------------------------------------------
module column_l2_normalizer_core
	import cln_pkg::*;
#(
	parameter int MAX_COLS     = 64,
	parameter int ELEMENT_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic signed [VALUE_W-1:0] element,
	input  logic                      last_of_pass,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kind,
	output logic [COL_W-1:0]          column,
	output logic signed [VALUE_W-1:0] value,
	output logic                      zero_norm,
	output logic                      last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int EB = ELEMENT_BITS;

	cln_state_t state_q;
	logic [CFG_W-1:0] cfg_q;
	logic [CFG_W-1:0] cols_eff;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    pos_s1;
	logic [AW-1:0]    col_q;
	logic             last_s1;
	logic             neg_s1;
	logic [EB-1:0]    mag_s1;
	logic [SUM_W-1:0] sq_s2;
	logic [SUM_W-1:0] base_s2;
	logic [VALUE_W-1:0] res_q;
	logic             zf_q;
	logic [MAX_COLS-1:0] sum_vld_q;

	logic [SUM_W-1:0]  sum_mem [MAX_COLS];
	logic [NORM_W-1:0] norm_mem [MAX_COLS];
	logic [SUM_W-1:0]  sum_rd_q;
	logic              vld_rd_q;
	logic [NORM_W-1:0] norm_rd_q;
	logic [AW-1:0]     rd_addr;

	logic             accept;
	logic             out_free;
	logic [EB-1:0]    raw;
	logic             neg_in;
	logic [EB-1:0]    mag_in;
	logic [CFG_W-1:0] pos_p1;
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic             col_is_last;

	cln_unit_stat_t    sq_stat;
	logic [NORM_W-1:0] sq_root;
	logic              sq_start;
	cln_unit_stat_t    dv_stat;
	logic [VALUE_W-1:0] dv_quot;
	logic              dv_start;
	logic              dv_zero;
	logic              dv_sat;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || !out_stall;

	assign raw    = element[EB-1:0];
	assign neg_in = raw[EB-1];
	assign mag_in = neg_in ? (~raw + 1'b1) : raw;

	always_comb begin
		if (cfg_q == '0) begin
			cols_eff = 7'd1;
		end else if (cfg_q > 7'(MAX_COLS)) begin
			cols_eff = 7'(MAX_COLS);
		end else begin
			cols_eff = cfg_q;
		end
	end

	assign pos_p1      = 7'(pos_q) + 7'd1;
	assign col_is_last = (7'(col_q) + 7'd1) == cols_eff;
	assign rd_addr     = (state_q == S_SW_RD) ? col_q : pos_q;

	assign sum_ext = {1'b0, base_s2} + {1'b0, sq_s2};
	assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	assign sq_start = (state_q == S_SW_START);
	assign dv_zero  = (norm_rd_q == '0);
	// A quotient of 2^31 or more saturates; it happens exactly when mag >= 2 * norm.
	assign dv_sat   = 33'(mag_s1) >= {norm_rd_q, 1'b0};
	assign dv_start = (state_q == S_DV_CHK) && !dv_zero && !dv_sat;

	cln_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (vld_rd_q ? sum_rd_q : '0),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	cln_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (64'({mag_s1, 30'b0})),
		.divisor  (norm_rd_q),
		.stat     (dv_stat),
		.quotient (dv_quot)
	);

	// Memories with a registered read port.
	always_ff @(posedge clk) begin
		sum_rd_q  <= sum_mem[rd_addr];
		norm_rd_q <= norm_mem[rd_addr];
		if (state_q == S_ACC_WR) begin
			sum_mem[pos_s1] <= sum_sat;
		end
		if (state_q == S_SW_OUT && out_free) begin
			norm_mem[col_q] <= sq_root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_rd_q <= 1'b0;
		end else begin
			vld_rd_q <= sum_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1  <= pos_q;
			last_s1 <= last_of_pass;
			neg_s1  <= neg_in;
			mag_s1  <= mag_in;
		end
		if (state_q == S_ACC_MUL) begin
			sq_s2   <= 64'(mag_s1 * mag_s1);
			base_s2 <= vld_rd_q ? sum_rd_q : '0;
		end
		if (state_q == S_DV_CHK) begin
			zf_q <= dv_zero;
			if (dv_zero) begin
				res_q <= '0;
			end else if (neg_s1) begin
				res_q <= 32'h8000_0000;
			end else begin
				res_q <= 32'h7FFF_FFFF;
			end
		end
		if (state_q == S_DV_WAIT && dv_stat.done) begin
			res_q <= neg_s1 ? (~dv_quot + 1'b1) : dv_quot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cfg_q     <= CFG_RESET;
			pos_q     <= '0;
			col_q     <= '0;
			sum_vld_q <= '0;
			out_valid <= 1'b0;
			kind      <= KIND_NORM;
			column    <= '0;
			value     <= '0;
			zero_norm <= 1'b0;
			last      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (last_of_pass || pos_p1 >= cols_eff) begin
							pos_q <= '0;
						end else begin
							pos_q <= AW'(pos_p1);
						end
						state_q <= (action == ACT_NORM) ? S_DV_CHK : S_ACC_MUL;
					end
				end
				S_ACC_MUL: begin
					state_q <= S_ACC_WR;
				end
				S_ACC_WR: begin
					sum_vld_q[pos_s1] <= 1'b1;
					col_q   <= '0;
					state_q <= last_s1 ? S_SW_RD : S_IDLE;
				end
				S_SW_RD: begin
					state_q <= S_SW_START;
				end
				S_SW_START: begin
					state_q <= S_SW_WAIT;
				end
				S_SW_WAIT: begin
					if (sq_stat.done) begin
						state_q <= S_SW_OUT;
					end
				end
				S_SW_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						kind      <= KIND_NORM;
						column    <= COL_W'(col_q);
						value     <= sq_root;
						zero_norm <= (sq_root == '0);
						last      <= col_is_last;
						if (col_is_last) begin
							sum_vld_q <= '0;
							state_q   <= S_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_SW_RD;
						end
					end
				end
				S_DV_CHK: begin
					state_q <= dv_start ? S_DV_WAIT : S_DV_OUT;
				end
				S_DV_WAIT: begin
					if (dv_stat.done) begin
						state_q <= S_DV_OUT;
					end
				end
				S_DV_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						kind      <= KIND_ELEM;
						column    <= COL_W'(pos_s1);
						value     <= res_q;
						zero_norm <= zf_q;
						last      <= last_s1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/cln_sqrt.sv]
// ----------------------------------------------------------------------------
// cln_sqrt
// Iterative floor square root of a 64-bit sum, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cln_sqrt
	import cln_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_W-1:0]    radicand,
	output cln_unit_stat_t      stat,
	output logic [NORM_W-1:0]   root
);

	logic [SUM_W-1:0]  rad_q;
	logic [35:0]       rem_q;
	logic [NORM_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [35:0]       rem_n;
	logic [35:0]       trial;
	logic              ge;

	assign rem_n = {rem_q[33:0], rad_q[SUM_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= ge ? (rem_n - trial) : rem_n;
			root_q <= {root_q[NORM_W-2:0], ge};
		end
	end

	assign stat = '{busy: busy_q, done: done_q};
	assign root = root_q;

endmodule

[hdl/cln_div.sv]
// ----------------------------------------------------------------------------
// cln_div
// Radix-4 restoring divider: 64-bit dividend by 32-bit divisor, 32-bit quotient.
// ----------------------------------------------------------------------------
module cln_div
	import cln_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SUM_W-1:0]    dividend,
	input  logic [NORM_W-1:0]   divisor,
	output cln_unit_stat_t      stat,
	output logic [VALUE_W-1:0]  quotient
);

	// The caller guarantees that the upper dividend half is below the divisor.
	logic [NORM_W-1:0]  d_q;
	logic [NORM_W-1:0]  r_q;
	logic [31:0]        lo_q;
	logic [VALUE_W-1:0] q_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [NORM_W:0]    r2_a;
	logic [NORM_W:0]    r2_b;
	logic [NORM_W-1:0]  r_a;
	logic [NORM_W-1:0]  r_b;
	logic               ge_a;
	logic               ge_b;

	always_comb begin
		r2_a = {r_q, lo_q[31]};
		ge_a = r2_a >= {1'b0, d_q};
		r_a  = ge_a ? NORM_W'(r2_a - {1'b0, d_q}) : r2_a[NORM_W-1:0];
		r2_b = {r_a, lo_q[30]};
		ge_b = r2_b >= {1'b0, d_q};
		r_b  = ge_b ? NORM_W'(r2_b - {1'b0, d_q}) : r2_b[NORM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q  <= divisor;
			r_q  <= dividend[SUM_W-1:32];
			lo_q <= dividend[31:0];
			q_q  <= '0;
		end else if (busy_q) begin
			r_q  <= r_b;
			lo_q <= {lo_q[29:0], 2'b00};
			q_q  <= {q_q[VALUE_W-3:0], ge_a, ge_b};
		end
	end

	assign stat     = '{busy: busy_q, done: done_q};
	assign quotient = q_q;

endmodule

[hdl/cln_checker.sv]
// ----------------------------------------------------------------------------
// cln_checker
// Port-level assertions for the column l2 normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "column_l2_normalizer_core_macros.svh"

module cln_checker
	import cln_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      action,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      kind,
	input logic signed [VALUE_W-1:0] value,
	input logic                      zero_norm
);

	// A stalled result keeps its value.
	`CLN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value), "stalled result changed")

	// Accepting a normalize transaction makes the block stall its input.
	`CLN_ASSERT_NEXT(a_norm_busy, in_valid && !in_stall && action == ACT_NORM, in_stall, "normalize transaction did not block input")

	// A column norm is flagged zero exactly when its value is zero.
	`CLN_ASSERT_NOW(a_norm_flag, out_valid && kind == KIND_NORM, zero_norm == (value == '0), "norm zero flag mismatch")

	// An element of a zero-norm column comes back as zero.
	`CLN_ASSERT_NOW(a_elem_zero, out_valid && kind == KIND_ELEM && zero_norm, value == '0, "zero-norm element is not zero")

endmodule

bind column_l2_normalizer_core cln_checker u_cln_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.action    (action),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.value     (value),
	.zero_norm (zero_norm)
);
